FILE: sv/psue_pkg.sv
package psue_pkg;

  localparam int NP = 64;
  localparam int ND = 64;
  localparam int PW = $clog2(NP);
  localparam int DW = $clog2(ND);
  localparam int EW = PW + DW;

  localparam logic [1:0] CFG_COG = 2'd0;
  localparam logic [1:0] CFG_SOC = 2'd1;
  localparam logic [1:0] CFG_MAX = 2'd2;

  localparam logic [1:0] K_BOUNDS = 2'd0;
  localparam logic [1:0] K_LOAD   = 2'd1;
  localparam logic [1:0] K_REPORT = 2'd2;
  localparam logic [1:0] K_UPDATE = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_G1, S_T1, S_G2, S_T2, S_CLAMP, S_FOLD, S_WB,
    S_CMP, S_COPY, S_COPYW, S_DONE
  } state_e;

  // Multiplier operation request from the sequencer
  typedef struct packed {
    logic signed [33:0] a;
    logic [19:0]        b;
  } mul_req_t;

endpackage

FILE: sv/psue_mul.sv
module psue_mul (
  input  logic              clk_i,
  input  psue_pkg::mul_req_t req_i,
  output logic signed [52:0] prod_o
);

  // Single shared signed-by-unsigned multiply, registered
  logic signed [52:0] prod_q;
  always_ff @(posedge clk_i) begin
    prod_q <= 53'(req_i.a * $signed({1'b0, req_i.b}));
  end
  assign prod_o = prod_q;

endmodule

FILE: sv/psue_ram.sv
module psue_ram #(
  parameter int AW = 12
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem [2**AW];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: sv/particle_swarm_update_engine_unit.sv
// Channel | Direction | Signals
// item    | in        | start_i, busy_o, kind_i .. rand_social_i
// result  | out       | done_o + new_position_o .. reflected_o
// config  | in        | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i
// Updates make four passes through the shared multiplier. Reports copy each
// improved best position one dimension at a time, paced by the position
// store read port.
// Reset clears control state and best valid flags and restores the gains;
// stores are undefined.
// The result strobe done_o is high for one cycle; the receiver cannot stall.
module particle_swarm_update_engine_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         kind_i,
  input  logic [5:0]         particle_i,
  input  logic [5:0]         dimension_i,
  input  logic signed [31:0] value_a_i,
  input  logic signed [31:0] value_b_i,
  input  logic [30:0]        value_c_i,
  input  logic [15:0]        rand_cognitive_i,
  input  logic [15:0]        rand_social_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  output logic               done_o,
  output logic signed [31:0] new_position_o,
  output logic signed [31:0] new_velocity_o,
  output logic               personal_improved_o,
  output logic               global_improved_o,
  output logic               reflected_o
);

  localparam int EW = psue_pkg::EW;
  localparam int DW = psue_pkg::DW;
  localparam int PW = psue_pkg::PW;

  psue_pkg::state_e state_q, state_d;

  // Configuration
  logic [15:0] cog_q, soc_q;
  logic        max_q;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cog_q <= 16'd8192; soc_q <= 16'd8192; max_q <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        psue_pkg::CFG_COG: cog_q <= cfg_data_i;
        psue_pkg::CFG_SOC: soc_q <= cfg_data_i;
        psue_pkg::CFG_MAX: max_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Captured item
  logic [1:0]         kind_q;
  logic [PW-1:0]      p_q;
  logic [DW-1:0]      d_q;
  logic signed [31:0] a_q, b_q;
  logic [30:0]        c_q;
  logic [15:0]        r1_q, r2_q;

  // Best tracking
  logic [psue_pkg::NP-1:0] pvalid_q;
  logic               gvalid_q;
  logic signed [31:0] gval_q;
  logic signed [31:0] pval [psue_pkg::NP];
  logic signed [31:0] pval_rd_q;
  logic               pimp_q, gimp_q, refl_q;
  logic [DW-1:0]      k_q;
  logic               copyg_q;

  // Work registers
  logic signed [33:0] x_q, v_q;
  logic signed [38:0] acc_q;
  logic signed [34:0] s_q;
  logic [30:0]        lim_q;
  logic signed [31:0] up_q, lo_q;

  // Stores
  logic        pos_we, vel_we, pbp_we, gbp_we, bnd_we;
  logic [EW-1:0] pos_wa, pos_ra, pbp_wa;
  logic [31:0] pos_wd, vel_wd, pbp_wd;
  logic [31:0] pos_rd, vel_rd, pbp_rd, gbp_rd, lo_rd, up_rd, lim_rd;
  logic [DW-1:0] gbp_wa;

  psue_ram #(.AW(EW)) u_pos (.clk_i, .we_i(pos_we), .waddr_i(pos_wa), .wdata_i(pos_wd),
    .raddr_i(pos_ra), .rdata_o(pos_rd));
  psue_ram #(.AW(EW)) u_vel (.clk_i, .we_i(vel_we), .waddr_i({p_q, d_q}), .wdata_i(vel_wd),
    .raddr_i({p_q, d_q}), .rdata_o(vel_rd));
  psue_ram #(.AW(EW)) u_pbp (.clk_i, .we_i(pbp_we), .waddr_i(pbp_wa), .wdata_i(pbp_wd),
    .raddr_i({p_q, d_q}), .rdata_o(pbp_rd));
  psue_ram #(.AW(DW)) u_gbp (.clk_i, .we_i(gbp_we), .waddr_i(gbp_wa), .wdata_i(pos_rd),
    .raddr_i(d_q), .rdata_o(gbp_rd));
  psue_ram #(.AW(DW)) u_lo (.clk_i, .we_i(bnd_we), .waddr_i(d_q), .wdata_i(a_q),
    .raddr_i(d_q), .rdata_o(lo_rd));
  psue_ram #(.AW(DW)) u_up (.clk_i, .we_i(bnd_we), .waddr_i(d_q), .wdata_i(b_q),
    .raddr_i(d_q), .rdata_o(up_rd));
  psue_ram #(.AW(DW)) u_lim (.clk_i, .we_i(bnd_we), .waddr_i(d_q),
    .wdata_i({1'b0, c_q}), .raddr_i(d_q), .rdata_o(lim_rd));

  // Shared multiplier
  psue_pkg::mul_req_t mreq;
  logic signed [52:0] prod;
  psue_mul u_mul (.clk_i, .req_i(mreq), .prod_o(prod));

  // Comparison of the reported objective
  logic pbetter, gbetter;
  assign pbetter = !pvalid_q[p_q] || (max_q ? (a_q > pval_rd_q) : (a_q < pval_rd_q));
  assign gbetter = !gvalid_q || (max_q ? (a_q > gval_q) : (a_q < gval_q));

  // Floor divide of the product by 2^16 via arithmetic shift
  logic signed [36:0] term;
  assign term = 37'(prod >>> 16);

  // Clamp the summed velocity to the limit
  logic signed [38:0] lim_s;
  assign lim_s = $signed({8'd0, lim_q});
  logic signed [34:0] vcl;
  always_comb begin
    if (acc_q < -lim_s) vcl = 35'(-lim_s);
    else if (acc_q > lim_s) vcl = 35'(lim_s);
    else vcl = 35'(acc_q);
  end

  logic signed [34:0] up_s, lo_s, fold;
  logic signed [34:0] vneg;
  logic               refl_now;
  assign up_s = 35'(up_q);
  assign lo_s = 35'(lo_q);
  assign vneg = (-35'(v_q)) >>> 1;
  assign refl_now = (s_q > up_s) || (s_q < lo_s);
  always_comb begin
    if (s_q > up_s) fold = up_s - ((s_q - up_s) >>> 1);
    else fold = lo_s + ((lo_s - s_q) >>> 1);
  end
  logic signed [31:0] sat_pos;
  logic signed [34:0] spos;
  assign spos = refl_now ? fold : s_q;
  always_comb begin
    if (spos > 35'sd2147483647) sat_pos = 32'sh7fffffff;
    else if (spos < -35'sd2147483648) sat_pos = 32'sh80000000;
    else sat_pos = 32'(spos);
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    mreq.a = '0; mreq.b = '0;
    pos_we = 1'b0; vel_we = 1'b0; pbp_we = 1'b0; gbp_we = 1'b0; bnd_we = 1'b0;
    pos_wa = {p_q, d_q}; pos_wd = a_q; vel_wd = b_q;
    pos_ra = {p_q, d_q};
    pbp_wa = {p_q, k_q}; pbp_wd = pos_rd; gbp_wa = k_q;
    unique case (state_q)
      psue_pkg::S_IDLE: if (start_i) state_d = psue_pkg::S_RD;
      psue_pkg::S_RD: begin
        unique case (kind_q)
          psue_pkg::K_BOUNDS: begin bnd_we = 1'b1; state_d = psue_pkg::S_DONE; end
          psue_pkg::K_LOAD: begin
            pos_we = 1'b1; vel_we = 1'b1; state_d = psue_pkg::S_DONE;
          end
          psue_pkg::K_REPORT: state_d = psue_pkg::S_CMP;
          default: state_d = psue_pkg::S_G1;
        endcase
      end
      psue_pkg::S_G1: begin
        mreq.a = 34'($signed({1'b0, cog_q})); mreq.b = {4'b0, r1_q};
        state_d = psue_pkg::S_T1;
      end
      psue_pkg::S_T1: begin
        mreq.a = (pvalid_q[p_q] ? 34'($signed(pbp_rd)) : x_q) - x_q;
        mreq.b = 20'(prod >>> 12);
        state_d = psue_pkg::S_G2;
      end
      psue_pkg::S_G2: begin
        mreq.a = 34'($signed({1'b0, soc_q})); mreq.b = {4'b0, r2_q};
        state_d = psue_pkg::S_T2;
      end
      psue_pkg::S_T2: begin
        mreq.a = (gvalid_q ? 34'($signed(gbp_rd)) : x_q) - x_q;
        mreq.b = 20'(prod >>> 12);
        state_d = psue_pkg::S_CLAMP;
      end
      psue_pkg::S_CLAMP: state_d = psue_pkg::S_FOLD;
      psue_pkg::S_FOLD: state_d = psue_pkg::S_WB;
      psue_pkg::S_WB: begin
        pos_we = 1'b1; vel_we = 1'b1;
        pos_wd = new_position_o; vel_wd = new_velocity_o;
        state_d = psue_pkg::S_DONE;
      end
      psue_pkg::S_CMP: begin
        pos_ra = {p_q, {DW{1'b0}}};
        state_d = (pbetter || gbetter) ? psue_pkg::S_COPY : psue_pkg::S_DONE;
      end
      psue_pkg::S_COPY: begin
        pos_ra = {p_q, k_q};
        state_d = psue_pkg::S_COPYW;
      end
      psue_pkg::S_COPYW: begin
        pbp_we = pimp_q && !copyg_q; gbp_we = gimp_q && copyg_q;
        if (k_q == DW'(psue_pkg::ND - 1)) begin
          state_d = (!copyg_q && gimp_q) ? psue_pkg::S_COPY : psue_pkg::S_DONE;
        end else begin
          state_d = psue_pkg::S_COPY;
        end
      end
      psue_pkg::S_DONE: state_d = psue_pkg::S_IDLE;
      default: state_d = psue_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= psue_pkg::S_IDLE;
    else state_q <= state_d;
  end

  // Control and best-state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvalid_q <= '0; gvalid_q <= 1'b0; gval_q <= '0;
      pimp_q <= 1'b0; gimp_q <= 1'b0; refl_q <= 1'b0;
      k_q <= '0; copyg_q <= 1'b0;
    end else begin
      unique case (state_q)
        psue_pkg::S_IDLE: begin
          pimp_q <= 1'b0; gimp_q <= 1'b0; refl_q <= 1'b0;
        end
        psue_pkg::S_CMP: begin
          pimp_q <= pbetter; gimp_q <= gbetter;
          copyg_q <= !pbetter; k_q <= '0;
          if (pbetter) pvalid_q[p_q] <= 1'b1;
          if (gbetter) begin gvalid_q <= 1'b1; gval_q <= a_q; end
        end
        psue_pkg::S_COPYW: begin
          if (k_q == DW'(psue_pkg::ND - 1)) begin
            k_q <= '0; copyg_q <= 1'b1;
          end else begin
            k_q <= k_q + 1'b1;
          end
        end
        psue_pkg::S_WB: refl_q <= refl_now;
        default: ;
      endcase
    end
  end

  // Personal best values, single write and single read
  always_ff @(posedge clk_i) begin
    if (state_q == psue_pkg::S_CMP && pbetter) pval[p_q] <= a_q;
    pval_rd_q <= pval[p_q];
  end

  // Item capture and datapath
  always_ff @(posedge clk_i) begin
    if (state_q == psue_pkg::S_IDLE && start_i) begin
      kind_q <= kind_i; p_q <= particle_i; d_q <= dimension_i;
      a_q <= value_a_i; b_q <= value_b_i; c_q <= value_c_i;
      r1_q <= rand_cognitive_i; r2_q <= rand_social_i;
    end
    unique case (state_q)
      psue_pkg::S_G1: begin
        x_q <= 34'($signed(pos_rd)); acc_q <= 39'($signed(vel_rd));
        lim_q <= lim_rd[30:0]; up_q <= up_rd; lo_q <= lo_rd;
      end
      psue_pkg::S_G2: acc_q <= acc_q + 39'(term);
      psue_pkg::S_CLAMP: acc_q <= acc_q + 39'(term);
      psue_pkg::S_FOLD: begin
        s_q <= 35'(x_q) + vcl; v_q <= 34'(vcl);
      end
      default: ;
    endcase
  end

  // Result register
  logic signed [31:0] npos_q, nvel_q;
  always_ff @(posedge clk_i) begin
    if (state_q == psue_pkg::S_IDLE) begin
      npos_q <= '0; nvel_q <= '0;
    end else if (state_q == psue_pkg::S_WB) begin
      npos_q <= new_position_o; nvel_q <= new_velocity_o;
    end
  end

  logic upd_out;
  assign upd_out = (state_q == psue_pkg::S_WB);
  assign new_position_o = upd_out ? sat_pos : npos_q;
  assign new_velocity_o = upd_out ? (refl_now ? 32'(vneg) : 32'(v_q)) : nvel_q;
  assign done_o = (state_q == psue_pkg::S_DONE);
  assign busy_o = (state_q != psue_pkg::S_IDLE);
  assign personal_improved_o = pimp_q;
  assign global_improved_o = gimp_q;
  assign reflected_o = refl_q;

  // Checks
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");
  a_gvalid_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gvalid_q |=> gvalid_q) else $error("global best lost");
  a_idle_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o) else $error("not idle after result");
endmodule
